@@ rtl/core/rwc_pkg.sv @@
// Shared types, constants and modular helpers for the rolling weak checksum.
// No dependencies; imported by every module of the block.
package rwc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned LEN_W  = 13;

    localparam logic [SUM_W:0]   CKSUM_MOD  = 17'd65521;
    localparam logic [LEN_W-1:0] LEN_RESET  = 13'd1024;
    localparam logic [SUM_W-1:0] SUM_A_INIT = 16'd1;
    localparam logic [SUM_W-1:0] SUM_B_INIT = 16'd0;

    // Item context carried from the accept stage to the roll stage
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              restart;
        logic              roll;
        logic              full;
        logic [LEN_W-1:0]  held;
        logic [LEN_W-1:0]  len;
    } item_meta_t;

    // Value known to be below 2*M
    function automatic logic [SUM_W-1:0] mod_fold2(input logic [SUM_W:0] x);
        logic [SUM_W:0] r;
        begin
            r = (x >= CKSUM_MOD) ? x - CKSUM_MOD : x;
            mod_fold2 = r[SUM_W-1:0];
        end
    endfunction

    // Value known to be below 3*M
    function automatic logic [SUM_W-1:0] mod_fold3(input logic [SUM_W+1:0] x);
        logic [SUM_W+1:0] m2;
        logic [SUM_W+1:0] r;
        begin
            m2 = {CKSUM_MOD, 1'b0};
            if (x >= m2)
                r = x - m2;
            else if (x >= {1'b0, CKSUM_MOD})
                r = x - {1'b0, CKSUM_MOD};
            else
                r = x;
            mod_fold3 = r[SUM_W-1:0];
        end
    endfunction

endpackage

@@ rtl/core/rolling_weak_checksum.sv @@
// Rolling Adler-32 weak checksum over a configurable sliding byte window.
// Depends on rwc_pkg, rwc_ctrl and rwc_window_ram.
// Usage:
//   Byte channel (data_byte, restart) with byte_valid/byte_stall; one byte per
//   transfer. restart set on a byte makes that byte the first of a new stream.
//   Result channel (checksum, window_full, bytes_held) with result_valid /
//   result_stall; exactly one result per byte, in order.
//   Config channel (window_length) with cfg_valid/cfg_ready; write it only when
//   the block is idle. A write also starts a new stream. cfg_ready is always 1.
// Timing:
//   Stages: accept/RAM access, drop term (L*old mod 65521), sum update, each
//   registered. Throughput is one byte per cycle while byte_stall is low,
//   set by the single read-first port of the window RAM, which returns the
//   byte being rolled out while the new byte is written.
// Reset:
//   Sums go to a=1, b=0, pointer and fill count to zero, window_length to 1024.
//   The window RAM is not cleared; only bytes of the current stream are rolled out.
// Stall:
//   A stalled result holds; stages behind it keep filling bubbles, and
//   byte_stall rises only when every stage is occupied.
module rolling_weak_checksum #(
    parameter int unsigned WINDOW_MAX = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rwc_pkg::LEN_W-1:0]  window_length,
    input  logic                       byte_valid,
    output logic                       byte_stall,
    input  logic [rwc_pkg::BYTE_W-1:0] data_byte,
    input  logic                       restart,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [31:0]                checksum,
    output logic                       window_full,
    output logic [rwc_pkg::LEN_W-1:0]  bytes_held
);
    import rwc_pkg::*;

    localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic             cfg_write;
    logic             accept;
    logic             en1, en2, en_o;
    logic [LEN_W-1:0] slot;
    logic [31:0]      slot_wide;
    item_meta_t       meta0;
    logic [BYTE_W-1:0] rolled_byte;

    // stage 1
    logic       v1_reg;
    item_meta_t meta1_reg;
    // stage 2
    logic             v2_reg;
    logic [SUM_W-1:0] da2_reg;
    logic [SUM_W-1:0] db2_reg;
    logic             restart2_reg;
    logic             full2_reg;
    logic [LEN_W-1:0] held2_reg;
    // output
    logic             vo_reg;
    logic [SUM_W-1:0] sum_a_reg, sum_a_next;
    logic [SUM_W-1:0] sum_b_reg, sum_b_next;
    logic             full_o_reg;
    logic [LEN_W-1:0] held_o_reg;

    // stage 1 combinational
    logic [LEN_W+BYTE_W-1:0] prod;
    logic [SUM_W:0]          prod_fold;
    logic [SUM_W-1:0]        drop;
    logic [SUM_W:0]          da_raw;
    logic [SUM_W-1:0]        da1;
    logic [SUM_W-1:0]        db1;
    // stage 2 combinational
    logic [SUM_W-1:0] base_a, base_b;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign en_o       = !vo_reg || !result_stall;
    assign en2        = !v2_reg || en_o;
    assign en1        = !v1_reg || en2;
    assign byte_stall = !en1;
    assign accept     = byte_valid && en1;

    rwc_ctrl #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .window_length (window_length),
        .accept        (accept),
        .data_byte     (data_byte),
        .restart       (restart),
        .slot          (slot),
        .meta          (meta0)
    );

    assign slot_wide = 32'(slot);

    rwc_window_ram #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .en    (accept),
        .addr  (slot_wide[AW-1:0]),
        .wdata (data_byte),
        .rdata (rolled_byte)
    );

    // drop = L*old mod M, using 2^16 == 15 (mod M)
    always_comb
    begin
        prod      = meta1_reg.len * {{LEN_W{1'b0}}, rolled_byte};
        prod_fold = {1'b0, prod[SUM_W-1:0]}
                  + (17'(prod[LEN_W+BYTE_W-1:SUM_W]) * 17'd15);
        drop      = mod_fold2(prod_fold);
        da_raw    = {9'd0, meta1_reg.data} + CKSUM_MOD - {9'd0, rolled_byte};
        if (meta1_reg.roll)
        begin
            da1 = mod_fold2(da_raw);
            db1 = CKSUM_MOD[SUM_W-1:0] - 16'd1 - drop;
        end
        else
        begin
            da1 = {8'd0, meta1_reg.data};
            db1 = '0;
        end
    end

    always_comb
    begin
        base_a     = restart2_reg ? SUM_A_INIT : sum_a_reg;
        base_b     = restart2_reg ? SUM_B_INIT : sum_b_reg;
        sum_a_next = mod_fold2({1'b0, base_a} + {1'b0, da2_reg});
        sum_b_next = mod_fold3({2'b0, base_b} + {2'b0, sum_a_next} + {2'b0, db2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
            sum_a_reg <= SUM_A_INIT;
            sum_b_reg <= SUM_B_INIT;
        end
        else
        begin
            if (en1)
                v1_reg <= byte_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en_o)
                vo_reg <= v2_reg;

            if (cfg_write)
            begin
                sum_a_reg <= SUM_A_INIT;
                sum_b_reg <= SUM_B_INIT;
            end
            else if (en_o && v2_reg)
            begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            meta1_reg <= meta0;
        if (en2 && v1_reg)
        begin
            da2_reg      <= da1;
            db2_reg      <= db1;
            restart2_reg <= meta1_reg.restart;
            full2_reg    <= meta1_reg.full;
            held2_reg    <= meta1_reg.held;
        end
        if (en_o && v2_reg)
        begin
            full_o_reg <= full2_reg;
            held_o_reg <= held2_reg;
        end
    end

    assign result_valid = vo_reg;
    assign checksum     = {sum_b_reg, sum_a_reg};
    assign window_full  = full_o_reg;
    assign bytes_held   = held_o_reg;

endmodule

@@ rtl/core/rwc_window_ram.sv @@
// Byte window store: single port, read-first, registered read data.
// Depends on rwc_pkg for the byte width.
module rwc_window_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [AW-1:0]              addr,
    input  logic [rwc_pkg::BYTE_W-1:0] wdata,
    output logic [rwc_pkg::BYTE_W-1:0] rdata
);
    import rwc_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Old byte comes out while the new one replaces it
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rwc_ctrl.sv @@
// Accept-stage control: window length register, write pointer, fill count.
// Depends on rwc_pkg for item_meta_t and widths.
module rwc_ctrl #(
    parameter int unsigned WINDOW_MAX = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [rwc_pkg::LEN_W-1:0]  window_length,
    input  logic                       accept,
    input  logic [rwc_pkg::BYTE_W-1:0] data_byte,
    input  logic                       restart,
    output logic [rwc_pkg::LEN_W-1:0]  slot,
    output rwc_pkg::item_meta_t        meta
);
    import rwc_pkg::*;

    localparam int unsigned LEN_MAXV = (1 << LEN_W) - 1;
    localparam int unsigned LEN_CAP  = (WINDOW_MAX > LEN_MAXV) ? LEN_MAXV : WINDOW_MAX;
    localparam logic [LEN_W-1:0] CAP = LEN_CAP[LEN_W-1:0];
    localparam logic [LEN_W-1:0] ONE = {{(LEN_W-1){1'b0}}, 1'b1};

    logic [LEN_W-1:0] wlen_reg;
    logic [LEN_W-1:0] ptr_reg,  ptr_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] ptr_cur;
    logic [LEN_W-1:0] fill_cur;
    logic [LEN_W:0]   ptr_inc;
    logic             roll;

    always_comb
    begin
        len = (wlen_reg == '0) ? ONE : wlen_reg;
        if (len > CAP)
            len = CAP;

        ptr_cur  = restart ? '0 : ptr_reg;
        if (ptr_cur >= len)
            ptr_cur = '0;
        fill_cur = restart ? '0 : fill_reg;

        roll      = (fill_cur >= len);
        fill_next = roll ? fill_cur : fill_cur + ONE;

        ptr_inc  = {1'b0, ptr_cur} + {1'b0, ONE};
        ptr_next = (ptr_inc >= {1'b0, len}) ? '0 : ptr_inc[LEN_W-1:0];

        meta.data    = data_byte;
        meta.restart = restart;
        meta.roll    = roll;
        meta.full    = (fill_next >= len);
        meta.held    = fill_next;
        meta.len     = len;
    end

    assign slot = ptr_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= LEN_RESET;
            ptr_reg  <= '0;
            fill_reg <= '0;
        end
        else if (cfg_write)
        begin
            // new length starts a fresh stream
            wlen_reg <= window_length;
            ptr_reg  <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule
